/* rtl/gef_pkg.sv */
// shared types and constants of the gray edge filter
package gef_pkg;

   localparam int PIX_W       = 8;
   localparam int GRAY_W      = 8;
   localparam int DIM_W       = 13;
   localparam int DIM_CMP_W   = 14;
   localparam int CSR_IDX_W   = 2;
   localparam int WSUM_W      = 15;
   localparam int RECIP_W     = 16;
   localparam int RECIP_SHIFT = 22;
   localparam int CONV_W      = 14;

   localparam int HEIGHT_LIMIT = 4096;
   localparam logic [DIM_W-1:0] WIDTH_RESET  = 13'd640;
   localparam logic [DIM_W-1:0] HEIGHT_RESET = 13'd480;

   localparam int FIFO_DEPTH = 4;
   localparam int FIFO_PTR_W = 2;
   localparam int FIFO_CNT_W = 3;

   // command codes
   localparam logic CMD_PIXEL = 1'b0;
   localparam logic CMD_PAD   = 1'b1;

   // luma weights in percent, and ceil(2^22 / 100) for the divide by 100
   localparam logic [WSUM_W-1:0]  W_RED      = 15'd30;
   localparam logic [WSUM_W-1:0]  W_GREEN    = 15'd59;
   localparam logic [WSUM_W-1:0]  W_BLUE     = 15'd11;
   localparam logic [RECIP_W-1:0] GRAY_RECIP = 16'd41944;

   // kernel taps
   localparam logic signed [CONV_W-1:0] K_CORNER = 14'sd1;
   localparam logic signed [CONV_W-1:0] K_SIDE   = 14'sd2;
   localparam logic signed [CONV_W-1:0] K_CENTER = -14'sd13;
   localparam logic signed [CONV_W-1:0] CLAMP_MAX = 14'sd255;

   typedef enum logic [CSR_IDX_W-1:0] {
      REG_IMAGE_WIDTH  = 2'd0,
      REG_IMAGE_HEIGHT = 2'd1
   } csr_reg_type;

   typedef logic [GRAY_W-1:0] gray_type;

   // [row][col], row 0 is the oldest line, col 2 the newest column
   typedef gray_type [2:0][2:0] window_type;

   typedef struct packed {
      logic s1_result;
      logic s2_result;
      logic frame_last;
   } win_status_type;

   typedef struct packed {
      logic [GRAY_W-1:0] edge_value;
      logic              frame_last;
   } result_type;

endpackage

/* rtl/gef_req_if.sv */
// pixel input channel
interface gef_req_if;
   logic                       valid;
   logic                       ready;
   logic                       command;
   logic [gef_pkg::PIX_W-1:0]  red;
   logic [gef_pkg::PIX_W-1:0]  green;
   logic [gef_pkg::PIX_W-1:0]  blue;

   modport source (output valid, command, red, green, blue, input ready);
   modport sink   (input valid, command, red, green, blue, output ready);
endinterface

/* rtl/gef_rsp_if.sv */
// edge result channel
interface gef_rsp_if;
   logic                        valid;
   logic                        ready;
   logic [gef_pkg::GRAY_W-1:0]  edge_value;
   logic                        frame_last;

   modport source (output valid, edge_value, frame_last, input ready);
   modport sink   (input valid, edge_value, frame_last, output ready);
endinterface

/* rtl/gef_csr_if.sv */
// register write channel
interface gef_csr_if;
   logic                           valid;
   logic                           ready;
   logic [gef_pkg::CSR_IDX_W-1:0]  index;
   logic [gef_pkg::DIM_W-1:0]      data;

   modport source (output valid, index, data, input ready);
   modport sink   (input valid, index, data, output ready);
endinterface

/* rtl/gef_window.sv */
// raster counters, gray conversion, line buffers and 3x3 window
module gef_window #(
   parameter int MAX_WIDTH = 4096
) (
   input  logic                                  clock,
   input  logic                                  reset,
   input  logic                                  accept,
   input  logic                                  command,
   input  logic [gef_pkg::PIX_W-1:0]             red,
   input  logic [gef_pkg::PIX_W-1:0]             green,
   input  logic [gef_pkg::PIX_W-1:0]             blue,
   input  logic [$clog2(MAX_WIDTH+2)-1:0]        eff_width,
   input  logic [gef_pkg::DIM_W-1:0]             eff_height,
   output gef_pkg::window_type                   window,
   output gef_pkg::win_status_type               status
);

   localparam int COL_W      = $clog2(MAX_WIDTH + 2);
   localparam int LINE_DEPTH = MAX_WIDTH + 2;
   localparam int DIM_W      = gef_pkg::DIM_W;
   localparam int PROD_W     = gef_pkg::WSUM_W + gef_pkg::RECIP_W;

   logic [COL_W-1:0]              col_ff, col_in;
   logic [DIM_W-1:0]              row_ff, row_in;
   logic                          v1_ff;
   logic                          emit1_ff, emit_in;
   logic                          last1_ff, last_in;
   logic [COL_W-1:0]              col1_ff;
   logic [gef_pkg::WSUM_W-1:0]    wsum_ff, wsum_in;
   gef_pkg::gray_type             old_rd_ff, new_rd_ff;
   logic                          result2_ff;
   logic                          last2_ff;
   gef_pkg::window_type           window_ff, window_in;

   gef_pkg::gray_type             older_mem [LINE_DEPTH];
   gef_pkg::gray_type             newer_mem [LINE_DEPTH];

   logic                          pix_ok;
   logic [PROD_W-1:0]             prod;
   gef_pkg::gray_type             gray;
   logic [COL_W-1:0]              w_last;
   logic [DIM_W-1:0]              h_last;

   assign w_last = eff_width + COL_W'(1);
   assign h_last = eff_height + DIM_W'(1);

   // positions beyond the image read as gray zero whatever the command
   assign pix_ok = (command == gef_pkg::CMD_PIXEL) && (row_ff < eff_height)
                   && (col_ff < eff_width);

   always_comb begin
      wsum_in = '0;
      if (pix_ok) begin
         wsum_in = gef_pkg::WSUM_W'(red)   * gef_pkg::W_RED
                 + gef_pkg::WSUM_W'(green) * gef_pkg::W_GREEN
                 + gef_pkg::WSUM_W'(blue)  * gef_pkg::W_BLUE;
      end
   end

   assign emit_in = (row_ff >= DIM_W'(2)) && (col_ff >= COL_W'(2))
                    && (row_ff <= h_last) && (col_ff <= w_last);
   assign last_in = (row_ff == h_last) && (col_ff == w_last);

   always_comb begin
      col_in = col_ff;
      row_in = row_ff;
      if (accept) begin
         if (col_ff >= w_last) begin
            col_in = '0;
            if (row_ff >= h_last) begin
               row_in = '0;
            end else begin
               row_in = row_ff + DIM_W'(1);
            end
         end else begin
            col_in = col_ff + COL_W'(1);
         end
      end
   end

   // divide by 100 through the reciprocal
   assign prod = PROD_W'(wsum_ff) * PROD_W'(gef_pkg::GRAY_RECIP);
   assign gray = gef_pkg::GRAY_W'(prod >> gef_pkg::RECIP_SHIFT);

   always_comb begin
      window_in = window_ff;
      if (v1_ff) begin
         for (int i = 0; i < 3; i++) begin
            window_in[i][0] = window_ff[i][1];
            window_in[i][1] = window_ff[i][2];
         end
         window_in[0][2] = old_rd_ff;
         window_in[1][2] = new_rd_ff;
         window_in[2][2] = gray;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         col_ff     <= '0;
         row_ff     <= '0;
         v1_ff      <= 1'b0;
         result2_ff <= 1'b0;
         window_ff  <= '0;
      end else begin
         col_ff     <= col_in;
         row_ff     <= row_in;
         v1_ff      <= accept;
         result2_ff <= v1_ff && emit1_ff;
         window_ff  <= window_in;
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         wsum_ff  <= wsum_in;
         emit1_ff <= emit_in;
         last1_ff <= last_in;
         col1_ff  <= col_ff;
      end
      if (v1_ff) begin
         last2_ff <= last1_ff;
      end
   end

   // line buffers: read at accept, written back in the cycle after
   always_ff @(posedge clock) begin
      if (accept) begin
         old_rd_ff <= older_mem[col_ff];
         new_rd_ff <= newer_mem[col_ff];
      end
      if (v1_ff) begin
         older_mem[col1_ff] <= new_rd_ff;
         newer_mem[col1_ff] <= gray;
      end
   end

   assign window            = window_ff;
   assign status.s1_result  = v1_ff && emit1_ff;
   assign status.s2_result  = result2_ff;
   assign status.frame_last = last2_ff;

   a_row_bound: assert property (@(posedge clock) disable iff (reset)
      row_ff <= DIM_W'(gef_pkg::HEIGHT_LIMIT + 1))
      else $error("row counter beyond the extended raster");

   a_col_bound: assert property (@(posedge clock) disable iff (reset)
      col_ff <= COL_W'(MAX_WIDTH + 1))
      else $error("column counter beyond the line buffer");

   a_last_wraps: assert property (@(posedge clock) disable iff (reset)
      (v1_ff && last1_ff) |-> (row_ff == '0 && col_ff == '0))
      else $error("frame end without raster wrap");

endmodule

/* rtl/gef_conv.sv */
// 3x3 kernel sum with clamp to 0..255
module gef_conv (
   input  gef_pkg::window_type          window,
   output logic [gef_pkg::GRAY_W-1:0]   edge_value
);

   localparam int CONV_W = gef_pkg::CONV_W;

   logic signed [CONV_W-1:0] corner;
   logic signed [CONV_W-1:0] side;
   logic signed [CONV_W-1:0] center;
   logic signed [CONV_W-1:0] sum;

   always_comb begin
      corner = CONV_W'(window[0][0]) + CONV_W'(window[0][2])
             + CONV_W'(window[2][0]) + CONV_W'(window[2][2]);
      side   = CONV_W'(window[0][1]) + CONV_W'(window[1][0])
             + CONV_W'(window[1][2]) + CONV_W'(window[2][1]);
      center = CONV_W'(window[1][1]);
      sum    = gef_pkg::K_CORNER * corner + gef_pkg::K_SIDE * side
             + gef_pkg::K_CENTER * center;
      if (sum < 0) begin
         edge_value = '0;
      end else if (sum > gef_pkg::CLAMP_MAX) begin
         edge_value = '1;
      end else begin
         edge_value = sum[gef_pkg::GRAY_W-1:0];
      end
   end

endmodule

/* rtl/gef_fifo.sv */
// small result queue between the filter pipeline and the result channel
module gef_fifo (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                push,
   input  gef_pkg::result_type                 push_data,
   input  logic                                pop_ready,
   output logic                                pop_valid,
   output gef_pkg::result_type                 pop_data,
   output logic [gef_pkg::FIFO_CNT_W-1:0]      count
);

   localparam int PTR_W = gef_pkg::FIFO_PTR_W;
   localparam int CNT_W = gef_pkg::FIFO_CNT_W;

   gef_pkg::result_type  entry_ff [gef_pkg::FIFO_DEPTH];
   logic [PTR_W-1:0]     head_ff, head_in;
   logic [PTR_W-1:0]     tail_ff, tail_in;
   logic [CNT_W-1:0]     count_ff, count_in;
   logic                 pop;

   assign pop_valid = (count_ff != '0);
   assign pop       = pop_valid && pop_ready;
   assign pop_data  = entry_ff[head_ff];
   assign count     = count_ff;

   always_comb begin
      head_in  = pop  ? head_ff + PTR_W'(1) : head_ff;
      tail_in  = push ? tail_ff + PTR_W'(1) : tail_ff;
      count_in = count_ff + CNT_W'(push) - CNT_W'(pop);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         head_ff  <= '0;
         tail_ff  <= '0;
         count_ff <= '0;
      end else begin
         head_ff  <= head_in;
         tail_ff  <= tail_in;
         count_ff <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         entry_ff[tail_ff] <= push_data;
      end
   end

   a_no_overflow: assert property (@(posedge clock) disable iff (reset)
      push |-> (count_ff != CNT_W'(gef_pkg::FIFO_DEPTH)) || pop)
      else $error("result queue overflow");

endmodule

/* rtl/gray_edge_filter_3x3.sv */
// top level of the streaming grayscale 3x3 edge filter
//
// req_chan carries one item of an extended (h+2) x (w+2) raster per transfer:
// real pixels (command pixel, rgb) inside the image, padding items around it.
// each item becomes gray floor((30r+59g+11b)/100), padding and positions
// outside the image count as zero. rsp_chan gives one clamped kernel result
// {1,2,1; 2,-13,2; 1,2,1} per image position in raster order, issued when
// extended position (i+2,j+2) arrives; frame_last marks the last one.
// csr_chan writes image_width (index 0) and image_height (index 1); it is
// always ready and should only be used while the filter is idle.
// each result passes the input registers, the window register and the queue.
// throughput: one item per cycle while req_chan.ready is high; the line buffers
// are read at accept and written back in the following cycle.
// a 4-entry result queue sits in front of rsp_chan; req_chan.ready drops only
// when the queue plus results still in the pipeline would fill it, so a
// stalled receiver holds back new items once promised results fill the queue.
// reset (synchronous) clears counters, window and queue and loads
// 640 x 480; the line buffers need no clearing.
module gray_edge_filter_3x3 #(
   parameter int MAX_WIDTH = 4096
) (
   input  logic         clock,
   input  logic         reset,
   gef_req_if.sink      req_chan,
   gef_rsp_if.source    rsp_chan,
   gef_csr_if.sink      csr_chan
);

   localparam int COL_W  = $clog2(MAX_WIDTH + 2);
   localparam int DIM_W  = gef_pkg::DIM_W;
   localparam int CMP_W  = gef_pkg::DIM_CMP_W;
   localparam int CNT_W  = gef_pkg::FIFO_CNT_W;

   // configuration registers
   logic [DIM_W-1:0]          image_width_ff, image_width_in;
   logic [DIM_W-1:0]          image_height_ff, image_height_in;

   logic [COL_W-1:0]          eff_width;
   logic [DIM_W-1:0]          eff_height;

   logic                      accept;
   logic [CNT_W-1:0]          fifo_count;
   logic [CNT_W-1:0]          committed;
   gef_pkg::window_type       window;
   gef_pkg::win_status_type   status;
   gef_pkg::result_type       result;
   gef_pkg::result_type       out_data;

   // register writes, unknown indexes are dropped
   assign csr_chan.ready = 1'b1;

   always_comb begin
      image_width_in  = image_width_ff;
      image_height_in = image_height_ff;
      if (csr_chan.valid) begin
         unique case (gef_pkg::csr_reg_type'(csr_chan.index))
            gef_pkg::REG_IMAGE_WIDTH:  image_width_in  = csr_chan.data;
            gef_pkg::REG_IMAGE_HEIGHT: image_height_in = csr_chan.data;
            default: ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         image_width_ff  <= gef_pkg::WIDTH_RESET;
         image_height_ff <= gef_pkg::HEIGHT_RESET;
      end else begin
         image_width_ff  <= image_width_in;
         image_height_ff <= image_height_in;
      end
   end

   // zero acts as one, oversize saturates
   always_comb begin
      if (image_width_ff == '0) begin
         eff_width = COL_W'(1);
      end else if (CMP_W'(image_width_ff) > CMP_W'(MAX_WIDTH)) begin
         eff_width = COL_W'(MAX_WIDTH);
      end else begin
         eff_width = COL_W'(image_width_ff);
      end
      if (image_height_ff == '0) begin
         eff_height = DIM_W'(1);
      end else if (CMP_W'(image_height_ff) > CMP_W'(gef_pkg::HEIGHT_LIMIT)) begin
         eff_height = DIM_W'(gef_pkg::HEIGHT_LIMIT);
      end else begin
         eff_height = image_height_ff;
      end
   end

   // queue slots already promised: stored results plus those still in flight
   assign committed      = fifo_count + CNT_W'(status.s1_result)
                           + CNT_W'(status.s2_result);
   assign req_chan.ready = (committed < CNT_W'(gef_pkg::FIFO_DEPTH));
   assign accept         = req_chan.valid && req_chan.ready;

   gef_window #(
      .MAX_WIDTH (MAX_WIDTH)
   ) u_window (
      .clock      (clock),
      .reset      (reset),
      .accept     (accept),
      .command    (req_chan.command),
      .red        (req_chan.red),
      .green      (req_chan.green),
      .blue       (req_chan.blue),
      .eff_width  (eff_width),
      .eff_height (eff_height),
      .window     (window),
      .status     (status)
   );

   gef_conv u_conv (
      .window     (window),
      .edge_value (result.edge_value)
   );

   assign result.frame_last = status.frame_last;

   gef_fifo u_fifo (
      .clock     (clock),
      .reset     (reset),
      .push      (status.s2_result),
      .push_data (result),
      .pop_ready (rsp_chan.ready),
      .pop_valid (rsp_chan.valid),
      .pop_data  (out_data),
      .count     (fifo_count)
   );

   assign rsp_chan.edge_value = out_data.edge_value;
   assign rsp_chan.frame_last = out_data.frame_last;

   a_credit_room: assert property (@(posedge clock) disable iff (reset)
      accept |-> (committed < CNT_W'(gef_pkg::FIFO_DEPTH)))
      else $error("item taken with no queue slot left");

   a_result_follows: assert property (@(posedge clock) disable iff (reset)
      status.s1_result |=> status.s2_result)
      else $error("result lost between pipeline stages");

endmodule

/* test/tb_gray_edge_filter_3x3.sv */
`timescale 1ns / 100ps
// testbench of the gray edge filter: raster stimulus, line-buffer predictor and result checks
module tb_gray_edge_filter_3x3;
   import gef_pkg::*;

   localparam int EDGE_MAX_WIDTH = 4096;
   localparam int LINE_DEPTH     = EDGE_MAX_WIDTH + 2;
   localparam int RANDOM_ITEMS   = 1750;
   // lets the filter pipeline empty after the last result, with margin
   localparam int SETTLE_CYCLES  = 8;
   localparam int REPORT_LIMIT   = 40;

   // one raster item as the producer sends it
   typedef struct {
      logic             command;
      logic [PIX_W-1:0] red;
      logic [PIX_W-1:0] green;
      logic [PIX_W-1:0] blue;
   } pixel_item_type;

   logic clock;
   logic reset;

   gef_req_if req_if ();
   gef_rsp_if rsp_if ();
   gef_csr_if csr_if ();

   gray_edge_filter_3x3 #(.MAX_WIDTH(EDGE_MAX_WIDTH)) dut (
      .clock    (clock),
      .reset    (reset),
      .req_chan (req_if),
      .rsp_chan (rsp_if),
      .csr_chan (csr_if)
   );

   // items waiting for the driver, edge results waiting for the dut
   pixel_item_type pixel_queue [$];
   result_type     edge_expect [$];

   // predictor copy of the filter state
   logic [DIM_W-1:0] cfg_width  = 13'd640;
   logic [DIM_W-1:0] cfg_height = 13'd480;
   gray_type    line_two_back [LINE_DEPTH];
   gray_type    line_one_back [LINE_DEPTH];
   gray_type    gray_window [3][3];
   int unsigned pos_row = 0;
   int unsigned pos_col = 0;
   // highest line buffer entry ever written, guards against reading unwritten entries
   int          line_top = -1;

   int unsigned items_sent   = 0;
   int unsigned results_seen = 0;
   int unsigned frames_seen  = 0;
   int unsigned error_count  = 0;

   bit idle_on   = 1'b1;
   bit req_fired = 1'b0;
   int req_gap   = 0;
   int rsp_gap   = 0;

   // clock: 10 ns period
   always begin
      clock = 1'b0;
      #5;
      clock = 1'b1;
      #5;
   end

   // out-of-range sizes: 0 acts as 1, anything above the limit as the limit
   function automatic int unsigned eff_dim(input logic [DIM_W-1:0] v, input int unsigned limit);
      if (v == 0) return 1;
      if (v > limit) return limit;
      return v;
   endfunction

   // kernel {1,2,1; 2,-13,2; 1,2,1}
   function automatic int tap_weight(input int x, input int y);
      if (x == 1 && y == 1) return -13;
      if (x == 1 || y == 1) return 2;
      return 1;
   endfunction

   // advance the predictor by one accepted item, queue the edge result it causes
   function automatic void predict_edge(input pixel_item_type it);
      int unsigned w, h, r, c, idx, gray;
      int          sum;
      result_type  res;
      w   = eff_dim(cfg_width, EDGE_MAX_WIDTH);
      h   = eff_dim(cfg_height, HEIGHT_LIMIT);
      r   = pos_row;
      c   = pos_col;
      idx = c % LINE_DEPTH;
      // padding and anything outside the image count as gray zero
      gray = 0;
      if (it.command == CMD_PIXEL && r < h && c < w)
         gray = (30 * int'(it.red) + 59 * int'(it.green) + 11 * int'(it.blue)) / 100;
      // shift the window left, new column holds rows r-2, r-1, r
      for (int x = 0; x < 3; x++) begin
         gray_window[x][0] = gray_window[x][1];
         gray_window[x][1] = gray_window[x][2];
      end
      gray_window[0][2] = line_two_back[idx];
      gray_window[1][2] = line_one_back[idx];
      gray_window[2][2] = gray_type'(gray);
      line_two_back[idx] = line_one_back[idx];
      line_one_back[idx] = gray_type'(gray);
      if (int'(idx) > line_top) line_top = idx;
      // result for image position (r-2, c-2)
      if (r >= 2 && c >= 2 && r <= h + 1 && c <= w + 1) begin
         sum = 0;
         for (int x = 0; x < 3; x++)
            for (int y = 0; y < 3; y++)
               sum += int'(gray_window[x][y]) * tap_weight(x, y);
         if (sum < 0) sum = 0;
         if (sum > 255) sum = 255;
         res.edge_value = sum[GRAY_W-1:0];
         res.frame_last = (r == h + 1 && c == w + 1);
         edge_expect.push_back(res);
      end
      // raster position, wraps at the end of a row and of the frame
      if (c >= w + 1) begin
         pos_col = 0;
         pos_row = (r >= h + 1) ? 0 : r + 1;
      end else begin
         pos_col = c + 1;
      end
   endfunction

   // items still needed to bring the raster position back to (0,0)
   function automatic int unsigned items_to_frame_start();
      int unsigned w, h, r, n;
      w = eff_dim(cfg_width, EDGE_MAX_WIDTH);
      h = eff_dim(cfg_height, HEIGHT_LIMIT);
      if (pos_row == 0 && pos_col == 0) return 0;
      n = (pos_col >= w + 1) ? 1 : w + 2 - pos_col;
      r = (pos_row >= h + 1) ? 0 : pos_row + 1;
      if (r != 0) n += (h + 2 - r) * (w + 2);
      return n;
   endfunction

   // color level, extremes a quarter of the time
   function automatic logic [PIX_W-1:0] rand_level();
      case ($urandom_range(0, 7))
         0: return 8'd0;
         1: return 8'd255;
         default: return PIX_W'($urandom_range(0, 255));
      endcase
   endfunction

   function automatic pixel_item_type make_item(input logic cmd);
      pixel_item_type it;
      it.command = cmd;
      it.red     = rand_level();
      it.green   = rand_level();
      it.blue    = rand_level();
      return it;
   endfunction

   function automatic void push_item(input logic cmd, input logic [PIX_W-1:0] r,
                                     input logic [PIX_W-1:0] g, input logic [PIX_W-1:0] b);
      pixel_item_type it;
      it.command = cmd;
      it.red     = r;
      it.green   = g;
      it.blue    = b;
      pixel_queue.push_back(it);
   endfunction

   // well-formed extended raster rows from (0,0) with random content; now and then a
   // padding item inside the image or a real pixel in a padding position
   function automatic int unsigned queue_raster(input int unsigned n_rows);
      int unsigned w, h, er;
      logic        in_image;
      w = eff_dim(cfg_width, EDGE_MAX_WIDTH);
      h = eff_dim(cfg_height, HEIGHT_LIMIT);
      for (int unsigned rr = 0; rr < n_rows; rr++) begin
         er = rr % (h + 2);
         for (int unsigned cc = 0; cc < w + 2; cc++) begin
            in_image = (er < h) && (cc < w);
            if (in_image)
               pixel_queue.push_back(make_item($urandom_range(0, 15) == 0 ? CMD_PAD : CMD_PIXEL));
            else
               pixel_queue.push_back(make_item($urandom_range(0, 7) == 0 ? CMD_PIXEL : CMD_PAD));
         end
      end
      return n_rows * (w + 2);
   endfunction

   // items with random command and content, position ignored
   function automatic void queue_noise(input int unsigned n);
      for (int unsigned i = 0; i < n; i++)
         pixel_queue.push_back(make_item($urandom_range(0, 1) ? CMD_PAD : CMD_PIXEL));
   endfunction

   // register write, only called while the filter is idle
   task automatic write_reg(input csr_reg_type which, input logic [DIM_W-1:0] value);
      @(negedge clock);
      csr_if.valid <= 1'b1;
      csr_if.index <= which;
      csr_if.data  <= value;
      do @(posedge clock); while (!csr_if.ready);
      if (which == REG_IMAGE_WIDTH) cfg_width = value;
      else cfg_height = value;
      @(negedge clock);
      csr_if.valid <= 1'b0;
   endtask

   // wait until every item is taken and every result is back, then let the pipe empty
   task automatic settle();
      while (pixel_queue.size() != 0 || req_if.valid || edge_expect.size() != 0)
         @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   // pixel driver: next item at the falling edge once the previous transfer is done
   always @(negedge clock) begin : pixel_driver
      pixel_item_type next_item;
      if (reset) begin
         req_if.valid <= 1'b0;
         req_gap      <= 0;
      end else if (!req_if.valid || req_fired) begin
         if (req_gap > 0) begin
            req_if.valid <= 1'b0;
            req_gap      <= req_gap - 1;
         end else if (idle_on && $urandom_range(0, 15) == 0) begin
            // idle burst: valid drops while req_gap counts down a random gap
            req_if.valid <= 1'b0;
            req_gap      <= $urandom_range(0, 18);
         end else if (pixel_queue.size() != 0) begin
            next_item       = pixel_queue.pop_front();
            req_if.valid   <= 1'b1;
            req_if.command <= next_item.command;
            req_if.red     <= next_item.red;
            req_if.green   <= next_item.green;
            req_if.blue    <= next_item.blue;
         end else begin
            req_if.valid <= 1'b0;
         end
      end
   end

   // result receiver: stalls in random bursts while rsp_gap counts down
   always @(negedge clock) begin
      if (rsp_gap > 0) begin
         rsp_if.ready <= 1'b0;
         rsp_gap      <= rsp_gap - 1;
      end else if (idle_on && !reset && $urandom_range(0, 15) == 0) begin
         rsp_if.ready <= 1'b0;
         rsp_gap      <= $urandom_range(0, 18);
      end else begin
         rsp_if.ready <= 1'b1;
      end
   end

   // monitor: check result transfers first, then feed accepted items to the predictor
   always @(posedge clock) begin : transfer_monitor
      result_type     want;
      pixel_item_type seen;
      req_fired <= req_if.valid && req_if.ready;
      if (!reset) begin
         if (rsp_if.valid && rsp_if.ready) begin
            results_seen++;
            if (rsp_if.frame_last) frames_seen++;
            if (edge_expect.size() == 0) begin
               error_count++;
               if (error_count <= REPORT_LIMIT)
                  $display("%0t: edge result with none pending: expected none, got value %0d last %0b",
                           $time, rsp_if.edge_value, rsp_if.frame_last);
            end else begin
               want = edge_expect.pop_front();
               if (rsp_if.edge_value !== want.edge_value || rsp_if.frame_last !== want.frame_last) begin
                  error_count++;
                  if (error_count <= REPORT_LIMIT)
                     $display("%0t: edge result mismatch: expected value %0d last %0b, got value %0d last %0b",
                              $time, want.edge_value, want.frame_last,
                              rsp_if.edge_value, rsp_if.frame_last);
               end
            end
         end
         if (req_if.valid && req_if.ready) begin
            seen.command = req_if.command;
            seen.red     = req_if.red;
            seen.green   = req_if.green;
            seen.blue    = req_if.blue;
            predict_edge(seen);
            items_sent++;
         end
      end
   end

   initial begin : stimulus
      int unsigned      n, w, h, random_items;
      logic [DIM_W-1:0] new_w, new_h;

      // known values on every input from time zero
      reset          = 1'b1;
      req_if.valid   = 1'b0;
      req_if.command = CMD_PIXEL;
      req_if.red     = '0;
      req_if.green   = '0;
      req_if.blue    = '0;
      rsp_if.ready   = 1'b1;
      csr_if.valid   = 1'b0;
      csr_if.index   = REG_IMAGE_WIDTH;
      csr_if.data    = '0;
      for (int i = 0; i < LINE_DEPTH; i++) begin
         line_two_back[i] = '0;
         line_one_back[i] = '0;
      end
      for (int x = 0; x < 3; x++)
         for (int y = 0; y < 3; y++)
            gray_window[x][y] = '0;

      repeat (11) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // reset geometry 640 x 480: first three extended rows give the first image row
      void'(queue_raster(3));
      settle();

      // out-of-range zero sizes, written mid-frame; the leftover row wraps without results
      write_reg(REG_IMAGE_WIDTH, 13'd0);
      write_reg(REG_IMAGE_HEIGHT, 13'd0);
      queue_noise(items_to_frame_start());
      // 1x1 image: padding command on the only pixel, real white pixels all around
      for (int i = 0; i < 9; i++)
         push_item(i == 0 ? CMD_PAD : CMD_PIXEL, 8'd255, 8'd255, 8'd255);
      settle();

      // 3x1 image of pure red, black and pure green, with junk in the padding area
      write_reg(REG_IMAGE_WIDTH, 13'd3);
      write_reg(REG_IMAGE_HEIGHT, 13'd1);
      push_item(CMD_PIXEL, 8'd255, 8'd0, 8'd0);
      push_item(CMD_PIXEL, 8'd0, 8'd0, 8'd0);
      push_item(CMD_PIXEL, 8'd0, 8'd255, 8'd0);
      push_item(CMD_PAD, 8'd0, 8'd0, 8'd0);
      push_item(CMD_PIXEL, 8'd255, 8'd255, 8'd255);
      for (int i = 0; i < 5; i++)
         push_item(CMD_PAD, 8'd255, 8'd255, 8'd255);
      push_item(CMD_PIXEL, 8'd0, 8'd0, 8'd255);
      for (int i = 0; i < 4; i++)
         push_item(CMD_PAD, 8'd0, 8'd0, 8'd0);
      settle();

      // extreme geometries, one thin frame each
      for (int i = 0; i < 4; i++) begin
         case (i)
            0: begin new_w = 13'd4096; new_h = 13'd1;    end
            1: begin new_w = 13'd1;    new_h = 13'd4096; end
            2: begin new_w = 13'd8191; new_h = 13'd0;    end
            default: begin new_w = 13'd0; new_h = 13'd8191; end
         endcase
         write_reg(REG_IMAGE_WIDTH, new_w);
         write_reg(REG_IMAGE_HEIGHT, new_h);
         void'(queue_raster(eff_dim(cfg_height, HEIGHT_LIMIT) + 2));
         settle();
      end

      // random phases: small images, whole frames, sometimes a broken tail
      random_items = 0;
      while (random_items < RANDOM_ITEMS) begin
         case ($urandom_range(0, 15))
            0: new_w = 13'd0;
            1: new_w = DIM_W'($urandom_range(13, 40));
            default: new_w = DIM_W'($urandom_range(1, 12));
         endcase
         case ($urandom_range(0, 15))
            0: new_h = 13'd0;
            1: new_h = DIM_W'($urandom_range(9, 20));
            default: new_h = DIM_W'($urandom_range(1, 8));
         endcase
         // mid-frame widening may only reach line entries written before
         if (!(pos_row == 0 && pos_col == 0) &&
             int'(eff_dim(new_w, EDGE_MAX_WIDTH)) + 1 > line_top)
            new_w = DIM_W'(line_top - 1);
         if ($urandom_range(0, 3) != 0) write_reg(REG_IMAGE_WIDTH, new_w);
         if ($urandom_range(0, 3) != 0) write_reg(REG_IMAGE_HEIGHT, new_h);
         // geometry changed mid-frame: run the raster out to the next frame start
         n = items_to_frame_start();
         queue_noise(n);
         random_items += n;
         w = eff_dim(cfg_width, EDGE_MAX_WIDTH);
         h = eff_dim(cfg_height, HEIGHT_LIMIT);
         random_items += queue_raster($urandom_range(1, 4) * (h + 2));
         if ($urandom_range(0, 3) == 0) begin
            n = $urandom_range(1, (w + 2) * (h + 2) - 1);
            queue_noise(n);
            random_items += n;
         end
         settle();
      end

      // last stretch at full rate on both sides
      idle_on = 1'b0;
      write_reg(REG_IMAGE_WIDTH, 13'd7);
      write_reg(REG_IMAGE_HEIGHT, 13'd5);
      queue_noise(items_to_frame_start());
      void'(queue_raster(3 * 7));
      settle();

      $display("covered %0d pixel transfers and %0d edge results in %0d complete frames,",
               items_sent, results_seen, frames_seen);
      $display("sizes from 0 to 8191 written, mid-frame geometry changes and full-rate streaming");
      if (error_count == 0 && edge_expect.size() == 0) begin
         $display("*** PASSED ***");
      end else begin
         $display("%0d errors, %0d edge results still pending", error_count, edge_expect.size());
         $display("*** FAILED ***");
      end
      $finish;
   end

   // watchdog, far beyond the slowest correct run
   initial begin
      #100_000_000;
      $display("%0t: watchdog expired with %0d edge results pending", $time, edge_expect.size());
      $display("*** FAILED ***");
      $finish;
   end

endmodule
